@@ design/unsorted_item_list_unit_macros.svh @@
// ----------------------------------------------------------------------------
// unsorted_item_list_unit_macros
// Assertion macros used by the list unit checker.
// ----------------------------------------------------------------------------
`ifndef UNSORTED_ITEM_LIST_UNIT_MACROS_SVH
`define UNSORTED_ITEM_LIST_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define UIL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UIL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/uil_pkg.sv @@
// ----------------------------------------------------------------------------
// uil_pkg
// Types and constants of the unsorted item list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uil_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int TOTAL_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 3'd0,
		CMD_DELETE     = 3'd1,
		CMD_CONTAINS   = 3'd2,
		CMD_CLEAR      = 3'd3,
		CMD_ITER_RESET = 3'd4,
		CMD_NEXT       = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_END       = 2'd3
	} status_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic shift_back;  // add: every entry moves one slot back
		logic close_gap;   // delete: entries from the match onwards move forward
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ design/uil_channels.sv @@
// ----------------------------------------------------------------------------
// uil_channels
// Command and response channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface uil_cmd_if import uil_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [VALUE_W-1:0] item_value;

	modport source (output valid, output command, output item_value, input ready);
	modport sink (input valid, input command, input item_value, output ready);
endinterface

interface uil_rsp_if import uil_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [VALUE_W-1:0]  item_out;
	logic [TOTAL_W-1:0]  entry_total;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output found, output item_out, output entry_total,
		output status, input ready);
	modport sink (input valid, input found, input item_out, input entry_total,
		input status, output ready);
endinterface

`default_nettype wire

@@ design/uil_cell.sv @@
// ----------------------------------------------------------------------------
// uil_cell
// One list slot: holds an entry, compares it with the probe and passes the
// first-match flag on down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module uil_cell import uil_pkg::*; #(
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic [ITEM_WIDTH-1:0] probe,
	input  wire logic                  live,
	input  wire logic [ITEM_WIDTH-1:0] prev_entry,
	input  wire logic [ITEM_WIDTH-1:0] next_entry,
	input  wire logic                  match_in,
	output      logic                  match_out,
	output      logic [ITEM_WIDTH-1:0] entry
);

	logic [ITEM_WIDTH-1:0] entry_q;

	// a match here or in any newer slot
	assign match_out = match_in | (live & (entry_q == probe));
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_back) begin
			entry_q <= prev_entry;
		end else if (ctl.close_gap && match_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire

@@ design/unsorted_item_list_unit.sv @@
// ----------------------------------------------------------------------------
// unsorted_item_list_unit
// Bounded unsorted list built as a row of slot cells, newest entry first.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (sink): command and item_value; a word is taken when valid and ready.
//     Commands: add, delete, contains, clear, reset iterator, next item.
//   rsp (source): found, item_out, entry_total and status, one word per
//     command, in command order.
//   The response word is registered; it is valid in the cycle after the
//   command is taken. Throughput: one command per cycle unless rsp stalls.
//   All cells compare with the probe in the same cycle and shift together
//   on add or from the match onwards on delete; no command waits on another.
//   Stall: while a response waits and rsp.ready is low, cmd.ready is low; a
//   new command is taken in the same cycle the waiting word leaves.
//   Reset: arst_n low empties the list and sets the iterator to the first
//   entry; no response is pending. Slot contents are not cleared.
//   entry_total carries the low five bits of the count.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_item_list_unit import uil_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	uil_cmd_if.sink  cmd,
	uil_rsp_if.source rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IN_W = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;

	logic [CW-1:0] count_q, count_nx;
	logic [CW-1:0] iter_q, iter_nx;

	logic                  rsp_valid_q;
	logic                  found_q;
	logic [VALUE_W-1:0]    item_q;
	logic [TOTAL_W-1:0]    total_q;
	status_t               status_q;

	logic                  accept;
	logic [ITEM_WIDTH-1:0] probe;
	logic [ITEM_WIDTH-1:0] entry_w [CAPACITY];
	logic [CAPACITY:0]     match_w;
	logic [CAPACITY-1:0]   live_w;
	logic [ITEM_WIDTH-1:0] rd_entry;
	cell_ctl_t             ctl;

	logic                  found_nx;
	logic [VALUE_W-1:0]    item_nx;
	status_t               status_nx;
	logic                  shift_req, gap_req;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign probe     = ITEM_WIDTH'(cmd.item_value[IN_W-1:0]);
	assign match_w[0] = 1'b0;

	assign ctl.shift_back = accept && shift_req;
	assign ctl.close_gap  = accept && gap_req;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] prev_w, next_w;

		assign live_w[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_w = probe;
		end else begin : g_body
			assign prev_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_w = entry_w[i];
		end else begin : g_inner
			assign next_w = entry_w[i+1];
		end

		uil_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.probe     (probe),
			.live      (live_w[i]),
			.prev_entry(prev_w),
			.next_entry(next_w),
			.match_in  (match_w[i]),
			.match_out (match_w[i+1]),
			.entry     (entry_w[i])
		);
	end

	// iterator read: and-or over the cells
	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_entry = rd_entry | (entry_w[i] & {ITEM_WIDTH{CW'(i) == iter_q}});
		end
	end

	always_comb begin
		count_nx  = count_q;
		iter_nx   = iter_q;
		found_nx  = 1'b0;
		item_nx   = '0;
		status_nx = ST_OK;
		shift_req = 1'b0;
		gap_req   = 1'b0;
		case (cmd_t'(cmd.command))
			CMD_ADD: begin
				if (count_q == CW'(CAPACITY)) begin
					status_nx = ST_FULL;
				end else begin
					shift_req = 1'b1;
					count_nx  = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (match_w[CAPACITY]) begin
					gap_req  = 1'b1;
					found_nx = 1'b1;
					count_nx = count_q - 1'b1;
				end else begin
					status_nx = ST_NOT_FOUND;
				end
			end
			CMD_CONTAINS: begin
				if (match_w[CAPACITY]) begin
					found_nx = 1'b1;
				end else begin
					status_nx = ST_NOT_FOUND;
				end
			end
			CMD_CLEAR: begin
				count_nx = '0;
				iter_nx  = '0;
			end
			CMD_ITER_RESET: begin
				iter_nx = '0;
			end
			CMD_NEXT: begin
				if (iter_q < count_q) begin
					item_nx = VALUE_W'(rd_entry[IN_W-1:0]);
					iter_nx = iter_q + 1'b1;
				end else begin
					status_nx = ST_END;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			iter_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nx;
				iter_q      <= iter_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q  <= found_nx;
			item_q   <= item_nx;
			total_q  <= TOTAL_W'(count_nx);
			status_q <= status_nx;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.item_out    = item_q;
	assign rsp.entry_total = total_q;
	assign rsp.status      = status_q;

endmodule

`default_nettype wire

@@ design/uil_checker.sv @@
// ----------------------------------------------------------------------------
// uil_checker
// Port-level assertions for the unsorted item list unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsorted_item_list_unit_macros.svh"

module uil_checker import uil_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire logic [CMD_W-1:0]    cmd_command,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic                rsp_found,
	input wire logic [VALUE_W-1:0]  rsp_item_out,
	input wire logic [TOTAL_W-1:0]  rsp_entry_total,
	input wire logic [STATUS_W-1:0] rsp_status
);

	`UIL_ASSERT_NEXT(a_word_after_cmd, cmd_valid && cmd_ready, rsp_valid, "no response word after command")

	`UIL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_item_out) && $stable(rsp_entry_total) && $stable(rsp_status), "stalled response word changed")

	`UIL_ASSERT_NEXT(a_clear_empties, cmd_valid && cmd_ready && cmd_command == CMD_CLEAR, rsp_entry_total == '0 && rsp_status == ST_OK, "clear left entries")

	`UIL_ASSERT_NEXT(a_contains_status, cmd_valid && cmd_ready && cmd_command == CMD_CONTAINS, rsp_found == (rsp_status == ST_OK) && rsp_item_out == '0, "contains found and status disagree")

endmodule

bind unsorted_item_list_unit uil_checker u_uil_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_command    (cmd.command),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_item_out   (rsp.item_out),
	.rsp_entry_total(rsp.entry_total),
	.rsp_status     (rsp.status)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unsorted item list unit. A scoreboard class
// keeps its own copy of the list and the iterator, works out the response
// word for every command taken, and checks the responses in order.
// Directed commands come first, then random command sequences under three
// idling profiles, with drain pauses between the profiles and a long
// receiver hold-off inside the first and the last profile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import uil_pkg::*;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] item_out;
		logic [TOTAL_W-1:0] entry_total;
		logic [STATUS_W-1:0] status;
	} list_reply_t;

	class list_scoreboard;
		logic [VALUE_W-1:0] entries[$];   // newest first
		int unsigned        walk_pos;
		list_reply_t        replies_due[$];
		int unsigned        errors;

		function new();
			walk_pos = 0;
			errors   = 0;
		endfunction

		function void note_command(logic [CMD_W-1:0] code, logic [VALUE_W-1:0] value);
			list_reply_t r;
			int          hit;
			r   = '0;
			hit = -1;
			if (code == CMD_DELETE || code == CMD_CONTAINS) begin
				for (int i = entries.size() - 1; i >= 0; i--)
					if (entries[i] == value)
						hit = i;
			end
			case (code)
				CMD_ADD: begin
					if (entries.size() >= CAPACITY_DEF)
						r.status = ST_FULL;
					else
						entries.push_front(value);
				end
				CMD_DELETE, CMD_CONTAINS: begin
					if (hit < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.found = 1'b1;
						if (code == CMD_DELETE)
							entries.delete(hit);
					end
				end
				CMD_CLEAR: begin
					entries.delete();
					walk_pos = 0;
				end
				CMD_ITER_RESET: begin
					walk_pos = 0;
				end
				CMD_NEXT: begin
					if (walk_pos < entries.size()) begin
						r.item_out = entries[walk_pos];
						walk_pos++;
					end else begin
						r.status = ST_END;
					end
				end
				default: begin
				end
			endcase
			r.entry_total = TOTAL_W'(entries.size());
			replies_due.push_back(r);
		endfunction

		function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_response(list_reply_t got);
			list_reply_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			report("found", VALUE_W'(want.found), VALUE_W'(got.found));
			report("item_out", want.item_out, got.item_out);
			report("entry_total", VALUE_W'(want.entry_total), VALUE_W'(got.entry_total));
			report("status", VALUE_W'(want.status), VALUE_W'(got.status));
		endfunction

		function logic [VALUE_W-1:0] any_entry();
			if (entries.size() == 0)
				return $urandom();
			return entries[$urandom_range(entries.size() - 1)];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	uil_cmd_if cmd_ch ();
	uil_rsp_if rsp_ch ();

	unsorted_item_list_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	list_scoreboard sb;
	int unsigned    send_idle;
	int unsigned    rsp_idle;
	int unsigned    issued;
	bit             long_hold;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_response({rsp_ch.found, rsp_ch.item_out, rsp_ch.entry_total,
				rsp_ch.status});
		if (cmd_ch.valid && cmd_ch.ready)
			sb.note_command(cmd_ch.command, cmd_ch.item_value);
	end

	initial begin
		int unsigned n;
		rsp_ch.ready <= 1'b0;
		forever begin
			if (long_hold) begin
				for (n = 0; n < 80; n++) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
				long_hold = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle);
				@(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(7);
		if (r < 55)
			return '1;
		if (r < 60)
			return '0;
		return $urandom();
	endfunction

	function automatic logic [VALUE_W-1:0] probe_value();
		if ($urandom_range(9) < 7)
			return sb.any_entry();
		return random_value();
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= code;
		cmd_ch.item_value <= value;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		issued++;
	endtask

	task automatic drain_responses();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned stop_at, pick, reps, k;
		stop_at = issued + quota;
		while (issued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 14) begin
				reps = CAPACITY_DEF - sb.entries.size() + $urandom_range(1, 3);
				for (k = 0; k < reps; k++)
					send_word(CMD_ADD, random_value());
			end else if (pick < 30) begin
				send_word(CMD_ITER_RESET, random_value());
				reps = sb.entries.size() + $urandom_range(0, 2);
				for (k = 0; k < reps; k++) begin
					if ($urandom_range(9) == 0)
						send_word($urandom_range(1) ? CMD_ADD : CMD_DELETE, probe_value());
					send_word(CMD_NEXT, random_value());
				end
			end else if (pick < 48) begin
				reps = $urandom_range(1, 6);
				for (k = 0; k < reps; k++)
					send_word(CMD_DELETE, probe_value());
			end else if (pick < 64) begin
				reps = $urandom_range(1, 6);
				for (k = 0; k < reps; k++)
					send_word(CMD_CONTAINS, probe_value());
			end else if (pick < 70) begin
				send_word(CMD_CLEAR, random_value());
			end else if (pick < 73) begin
				send_word(CMD_W'($urandom_range(6, 7)), random_value());
			end else begin
				reps = $urandom_range(1, 6);
				for (k = 0; k < reps; k++)
					send_word(CMD_W'($urandom_range(0, 5)), probe_value());
			end
		end
	endtask

	task automatic directed_words();
		send_word(CMD_NEXT, '0);
		send_word(CMD_CONTAINS, 32'h5);
		send_word(CMD_DELETE, 32'h5);
		send_word(CMD_ADD, '0);
		send_word(CMD_ADD, '1);
		send_word(CMD_ADD, '0);
		send_word(CMD_CONTAINS, '1);
		send_word(CMD_CONTAINS, 32'h1234_5678);
		send_word(CMD_NEXT, '0);
		send_word(CMD_DELETE, '0);
		send_word(CMD_NEXT, '1);
		send_word(CMD_NEXT, '0);
		send_word(CMD_ITER_RESET, '1);
		send_word(CMD_NEXT, '0);
		send_word(3'd6, 32'hA5A5_5A5A);
		send_word(3'd7, '1);
		send_word(CMD_DELETE, '0);
		send_word(CMD_CONTAINS, '0);
		send_word(CMD_CLEAR, '1);
		send_word(CMD_NEXT, '0);
		send_word(CMD_DELETE, '1);
	endtask

	initial begin
		sb        = new();
		send_idle = 21;
		rsp_idle  = 54;
		issued    = 0;
		long_hold = 1'b0;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.command    <= '0;
		cmd_ch.item_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();
		drain_responses();

		random_phase(150);
		long_hold = 1'b1;
		random_phase(300);
		drain_responses();

		send_idle = 54;
		rsp_idle  = 21;
		random_phase(450);
		drain_responses();

		send_idle = 0;
		rsp_idle  = 0;
		random_phase(100);
		long_hold = 1'b1;
		random_phase(350);
		drain_responses();

		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.replies_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/uil_pkg.sv
design/uil_channels.sv
design/uil_cell.sv
design/unsorted_item_list_unit.sv
design/uil_checker.sv
tb/tb.sv
